>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion helpers for the edge finder checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define RKEF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define RKEF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rkef_pkg.sv
// ----------------------------------------------------------------------------
// rkef_pkg
// shared types, constants and helpers of the row kernel edge finder
// ----------------------------------------------------------------------------
package rkef_pkg;

  // sizing
  localparam int MaxKernel  = 16;
  localparam int RowWidth   = 4096;
  localparam int MaxRows    = 4096;
  localparam int QueueDepth = 2;

  // field widths
  localparam int HeightW   = 16;
  localparam int StrengthW = 20;
  localparam int OutColW   = 12;
  localparam int RowIdxW   = 12;
  localparam int KernelW   = 5;
  localparam int DirW      = 3;
  localparam int PickW     = 2;
  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 20;

  // derived widths
  localparam int KSelW    = $clog2(MaxKernel + 1);
  localparam int ColCntW  = $clog2(RowWidth + 1);
  localparam int GrpW     = HeightW + 2;
  localparam int Groups   = (MaxKernel + 3) / 4;
  localparam int SumW     = HeightW + $clog2(MaxKernel) + 1;
  localparam int QPtrW    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW    = $clog2(QueueDepth + 1);

  localparam logic [HeightW-1:0]   NullSample  = {1'b1, {(HeightW-1){1'b0}}};
  localparam logic [StrengthW-1:0] StrengthMax = {StrengthW{1'b1}};

  // register indexes
  typedef enum logic [CfgAddrW-1:0] {
    REG_KERNEL_SIZE = 3'd0,
    REG_LOWER_THR   = 3'd1,
    REG_UPPER_THR   = 3'd2,
    REG_EDGE_DIR    = 3'd3,
    REG_PICK_RULE   = 3'd4,
    REG_Z_LOW       = 3'd5,
    REG_Z_HIGH      = 3'd6,
    REG_ZERO_LEVEL  = 3'd7
  } rkef_reg_e;

  // direction rules
  typedef enum logic [DirW-1:0] {
    DIR_ANY       = 3'd0,
    DIR_RISE      = 3'd1,
    DIR_RISE_NULL = 3'd2,
    DIR_FALL      = 3'd3,
    DIR_FALL_NULL = 3'd4
  } rkef_dir_e;

  // pick rules
  typedef enum logic [PickW-1:0] {
    PICK_PEAK  = 2'd0,
    PICK_FIRST = 2'd1,
    PICK_LAST  = 2'd2
  } rkef_pick_e;

  typedef struct packed {
    logic [KernelW-1:0]          kernel_size;
    logic [StrengthW-1:0]        lower_thr;
    logic [StrengthW-1:0]        upper_thr;
    logic [DirW-1:0]             edge_dir;
    logic [PickW-1:0]            pick_rule;
    logic signed [HeightW-1:0]   z_low;
    logic signed [HeightW-1:0]   z_high;
    logic signed [HeightW-1:0]   zero_level;
  } rkef_cfg_t;

  typedef logic [MaxKernel:0][HeightW-1:0] rkef_taps_t;

  // per-sample bookkeeping carried alongside the window
  typedef struct packed {
    logic                 eval;
    logic [OutColW-1:0]   start_col;
    logic                 row_end;
    logic                 frame_start;
    logic [RowIdxW-1:0]   row_idx;
  } rkef_meta_t;

  typedef struct packed {
    rkef_taps_t taps;
    rkef_meta_t meta;
  } rkef_entry_t;

  // kernel size clamped to 1..MaxKernel
  function automatic logic [KSelW-1:0] eff_kernel(input logic [KernelW-1:0] ks);
    logic [KSelW-1:0] k;
    if (ks == '0) begin
      k = KSelW'(1);
    end else if (int'(ks) > MaxKernel) begin
      k = KSelW'(MaxKernel);
    end else begin
      k = KSelW'(ks);
    end
    return k;
  endfunction

endpackage

>>> rtl/rkef_ifs.sv
// ----------------------------------------------------------------------------
// rkef_ifs
// valid/ready channel interfaces for samples, results and register writes
// ----------------------------------------------------------------------------

// height sample channel
interface rkef_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rkef_pkg::HeightW-1:0]  height;
  logic                                 row_end;
  logic                                 frame_start;

  modport source (output valid, height, row_end, frame_start, input ready);
  modport sink   (input valid, height, row_end, frame_start, output ready);
endinterface

// per-row result channel
interface rkef_result_if;
  logic                               valid;
  logic                               ready;
  logic [rkef_pkg::RowIdxW-1:0]       row_index;
  logic                               edge_found;
  logic [rkef_pkg::OutColW-1:0]       edge_column;
  logic [rkef_pkg::StrengthW-1:0]     edge_strength;

  modport source (output valid, row_index, edge_found, edge_column, edge_strength,
                  input ready);
  modport sink   (input valid, row_index, edge_found, edge_column, edge_strength,
                  output ready);
endinterface

// register write channel
interface rkef_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rkef_pkg::CfgAddrW-1:0]    addr;
  logic [rkef_pkg::CfgDataW-1:0]    data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

>>> rtl/rkef_queue.sv
// ----------------------------------------------------------------------------
// rkef_queue
// short fifo of window snapshots between the front and the back end
// ----------------------------------------------------------------------------
module rkef_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rkef_pkg::rkef_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output rkef_pkg::rkef_entry_t entry_o,
  output logic                  empty_o
);

  rkef_pkg::rkef_entry_t            mem_q [rkef_pkg::QueueDepth];
  logic [rkef_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [rkef_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [rkef_pkg::QCntW-1:0]       count_q, count_d;
  logic                             do_push, do_pop;

  assign full_o  = (count_q == rkef_pkg::QCntW'(rkef_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == rkef_pkg::QPtrW'(rkef_pkg::QueueDepth - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == rkef_pkg::QPtrW'(rkef_pkg::QueueDepth - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> rtl/rkef_front.sv
// ----------------------------------------------------------------------------
// rkef_front
// takes samples, shifts the window and tags each transaction for the back end
// ----------------------------------------------------------------------------
module rkef_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rkef_sample_if.sink           samp_i,
  input  rkef_pkg::rkef_cfg_t   cfg_i,
  input  logic                  full_i,
  output logic                  push_o,
  output rkef_pkg::rkef_entry_t entry_o
);

  rkef_pkg::rkef_taps_t             taps_q, taps_d;
  logic [rkef_pkg::ColCntW-1:0]     col_cnt_q, col_cnt_d;
  logic [rkef_pkg::RowIdxW-1:0]     row_cnt_q, row_cnt_d;
  logic [rkef_pkg::ColCntW-1:0]     col_base;
  logic [rkef_pkg::RowIdxW-1:0]     row_idx;
  logic [rkef_pkg::KSelW-1:0]       k;
  logic                             in_range;
  logic                             accept;

  assign samp_i.ready = !full_i;
  assign accept       = samp_i.valid && !full_i;
  assign push_o       = accept;
  assign k            = rkef_pkg::eff_kernel(cfg_i.kernel_size);

  // frame start restarts the counters before the sample is placed
  assign col_base = samp_i.frame_start ? '0 : col_cnt_q;
  assign row_idx  = samp_i.frame_start ? '0 : row_cnt_q;
  assign in_range = (col_base < rkef_pkg::ColCntW'(rkef_pkg::RowWidth));

  // window shift, newest sample at tap zero
  always_comb begin
    taps_d = taps_q;
    if (in_range) begin
      taps_d[0] = samp_i.height;
      for (int i = 1; i <= rkef_pkg::MaxKernel; i++) begin
        taps_d[i] = taps_q[i-1];
      end
    end
  end

  // column and row counting
  always_comb begin
    col_cnt_d = in_range ? col_base + 1'b1 : col_base;
    row_cnt_d = row_idx;
    if (samp_i.row_end) begin
      col_cnt_d = '0;
      row_cnt_d = (row_idx == rkef_pkg::RowIdxW'(rkef_pkg::MaxRows - 1)) ?
                  '0 : row_idx + 1'b1;
    end
  end

  // snapshot pushed with each transaction
  always_comb begin
    entry_o.taps             = taps_d;
    entry_o.meta.eval        = in_range && (col_base >= rkef_pkg::ColCntW'(k));
    entry_o.meta.start_col   = rkef_pkg::OutColW'(col_base - rkef_pkg::ColCntW'(k));
    entry_o.meta.row_end     = samp_i.row_end;
    entry_o.meta.frame_start = samp_i.frame_start;
    entry_o.meta.row_idx     = row_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q    <= {(rkef_pkg::MaxKernel + 1){rkef_pkg::NullSample}};
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (accept) begin
      taps_q    <= taps_d;
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
    end
  end

endmodule

>>> rtl/rkef_back.sv
// ----------------------------------------------------------------------------
// rkef_back
// window evaluation pipeline, edge selection and result register
// ----------------------------------------------------------------------------
module rkef_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rkef_pkg::rkef_cfg_t   cfg_i,
  input  rkef_pkg::rkef_entry_t entry_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  rkef_result_if.source         res_o
);

  // difference of two samples as a magnitude
  function automatic logic [rkef_pkg::HeightW-1:0] abs_diff(
    input logic signed [rkef_pkg::HeightW-1:0] a,
    input logic signed [rkef_pkg::HeightW-1:0] b
  );
    logic signed [rkef_pkg::HeightW:0] d;
    d = $signed({a[rkef_pkg::HeightW-1], a}) - $signed({b[rkef_pkg::HeightW-1], b});
    return d[rkef_pkg::HeightW] ? rkef_pkg::HeightW'(-d) : rkef_pkg::HeightW'(d);
  endfunction

  // contribution of one tap under the direction rule
  function automatic logic [rkef_pkg::HeightW-1:0] tap_term(
    input logic signed [rkef_pkg::HeightW-1:0] s,
    input logic signed [rkef_pkg::HeightW-1:0] e,
    input logic [rkef_pkg::DirW-1:0]           dir,
    input logic signed [rkef_pkg::HeightW-1:0] zero
  );
    logic                        sn, en_n;
    logic [rkef_pkg::HeightW-1:0] t;
    sn   = (s == rkef_pkg::NullSample);
    en_n = (e == rkef_pkg::NullSample);
    t    = '0;
    case (dir)
      rkef_pkg::DIR_ANY:       if (!sn && !en_n) t = abs_diff(e, s);
      rkef_pkg::DIR_RISE:      if (!sn && !en_n && s < e) t = abs_diff(e, s);
      rkef_pkg::DIR_RISE_NULL: if (sn && !en_n) t = abs_diff(e, zero);
      rkef_pkg::DIR_FALL:      if (!sn && !en_n && s > e) t = abs_diff(s, e);
      rkef_pkg::DIR_FALL_NULL: if (en_n && !sn) t = abs_diff(s, zero);
      default:                 t = '0;
    endcase
    return t;
  endfunction

  logic [rkef_pkg::KSelW-1:0] k;
  logic                       adv;

  // stage 1: per-tap terms and band check
  logic                                           s1_valid_q;
  rkef_pkg::rkef_meta_t                           s1_meta_q;
  logic                                           s1_reject_q, s1_reject_d;
  logic [rkef_pkg::MaxKernel-1:0][rkef_pkg::HeightW-1:0] s1_terms_q, s1_terms_d;

  // stage 2: group sums
  logic                                           s2_valid_q;
  rkef_pkg::rkef_meta_t                           s2_meta_q;
  logic                                           s2_reject_q;
  logic [rkef_pkg::Groups-1:0][rkef_pkg::GrpW-1:0] s2_grp_q, s2_grp_d;

  // stage 3: saturated strength
  logic                                           s3_valid_q;
  rkef_pkg::rkef_meta_t                           s3_meta_q;
  logic                                           s3_reject_q;
  logic [rkef_pkg::StrengthW-1:0]                 s3_str_q, s3_str_d;

  // selection state
  logic [rkef_pkg::StrengthW-1:0] best_str_q, best_str_d;
  logic [rkef_pkg::OutColW-1:0]   best_col_q, best_col_d;
  logic [rkef_pkg::StrengthW-1:0] sel_str;
  logic [rkef_pkg::OutColW-1:0]   sel_col;

  // result register
  logic                           out_valid_q;
  logic [rkef_pkg::RowIdxW-1:0]   out_row_q;
  logic                           out_found_q;
  logic [rkef_pkg::OutColW-1:0]   out_col_q;
  logic [rkef_pkg::StrengthW-1:0] out_str_q;

  assign k     = rkef_pkg::eff_kernel(cfg_i.kernel_size);
  assign adv   = !out_valid_q || res_o.ready;
  assign pop_o = adv && !empty_i;

  assign res_o.valid         = out_valid_q;
  assign res_o.row_index     = out_row_q;
  assign res_o.edge_found    = out_found_q;
  assign res_o.edge_column   = out_col_q;
  assign res_o.edge_strength = out_str_q;

  // terms against the window start, band check on taps one to k
  always_comb begin
    logic signed [rkef_pkg::HeightW-1:0] start_v;
    logic signed [rkef_pkg::HeightW-1:0] v;
    start_v     = entry_i.taps[k];
    s1_reject_d = 1'b0;
    for (int j = 0; j < rkef_pkg::MaxKernel; j++) begin
      s1_terms_d[j] = (j < int'(k)) ?
                      tap_term(start_v, entry_i.taps[j], cfg_i.edge_dir, cfg_i.zero_level) :
                      '0;
    end
    for (int j = 1; j <= rkef_pkg::MaxKernel; j++) begin
      v = entry_i.taps[j];
      if (j <= int'(k) && v != rkef_pkg::NullSample &&
          (v < cfg_i.z_low || v > cfg_i.z_high)) begin
        s1_reject_d = 1'b1;
      end
    end
  end

  // sums of four terms
  always_comb begin
    for (int g = 0; g < rkef_pkg::Groups; g++) begin
      s2_grp_d[g] = '0;
      for (int t = 0; t < 4; t++) begin
        if (g * 4 + t < rkef_pkg::MaxKernel) begin
          s2_grp_d[g] = s2_grp_d[g] + rkef_pkg::GrpW'(s1_terms_q[g*4+t]);
        end
      end
    end
  end

  // total with saturation at the strength width
  always_comb begin
    logic [rkef_pkg::SumW-1:0] total;
    total = '0;
    for (int g = 0; g < rkef_pkg::Groups; g++) begin
      total = total + rkef_pkg::SumW'(s2_grp_q[g]);
    end
    s3_str_d = (total > rkef_pkg::SumW'(rkef_pkg::StrengthMax)) ?
               rkef_pkg::StrengthMax : rkef_pkg::StrengthW'(total);
  end

  // threshold band and pick rule
  always_comb begin
    logic [rkef_pkg::StrengthW-1:0] base_str;
    logic [rkef_pkg::OutColW-1:0]   base_col;
    logic                           ok;
    logic                           take;
    base_str = s3_meta_q.frame_start ? '0 : best_str_q;
    base_col = s3_meta_q.frame_start ? '0 : best_col_q;
    ok = s3_meta_q.eval && !s3_reject_q && (s3_str_q != '0) &&
         (s3_str_q >= cfg_i.lower_thr) && (s3_str_q <= cfg_i.upper_thr);
    case (cfg_i.pick_rule)
      rkef_pkg::PICK_PEAK:  take = s3_str_q > base_str;
      rkef_pkg::PICK_FIRST: take = (base_str == '0);
      rkef_pkg::PICK_LAST:  take = 1'b1;
      default:              take = 1'b0;
    endcase
    sel_str = (ok && take) ? s3_str_q : base_str;
    sel_col = (ok && take) ? s3_meta_q.start_col : base_col;
    best_str_d = s3_meta_q.row_end ? '0 : sel_str;
    best_col_d = s3_meta_q.row_end ? '0 : sel_col;
  end

  // pipeline valids, selection state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      best_str_q  <= '0;
      best_col_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= !empty_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q && s3_meta_q.row_end;
      if (s3_valid_q) begin
        best_str_q <= best_str_d;
        best_col_q <= best_col_d;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_meta_q   <= entry_i.meta;
      s1_reject_q <= s1_reject_d;
      s1_terms_q  <= s1_terms_d;
      s2_meta_q   <= s1_meta_q;
      s2_reject_q <= s1_reject_q;
      s2_grp_q    <= s2_grp_d;
      s3_meta_q   <= s2_meta_q;
      s3_reject_q <= s2_reject_q;
      s3_str_q    <= s3_str_d;
      if (s3_valid_q && s3_meta_q.row_end) begin
        out_row_q   <= s3_meta_q.row_idx;
        out_found_q <= (sel_str != '0);
        out_col_q   <= sel_col;
        out_str_q   <= sel_str;
      end
    end
  end

endmodule

>>> rtl/row_kernel_edge_finder.sv
// ----------------------------------------------------------------------------
// row_kernel_edge_finder
// kernel difference edge detector over a stream of height rows
// ----------------------------------------------------------------------------
// Takes one signed height sample per clock and reports one result per row,
// carrying the row index, a found flag, the window start column and the edge
// strength. Sustained rate is one sample per cycle while results are taken:
// the front shifts the sample window in the cycle of acceptance, and the back
// end is a three-stage pipeline (tap terms and band check, partial sums,
// saturated total) followed by the selection step that loads the result
// register. A two-entry queue between front and back absorbs a stalled
// result; once it is full the sample channel holds off. Registers are to be
// written only while the block is idle, by the user; the block itself does
// not enforce it. Register writes are always ready.
// ----------------------------------------------------------------------------
module row_kernel_edge_finder (
  input  logic           clk_i,
  input  logic           rst_ni,
  rkef_sample_if.sink    samp_i,
  rkef_result_if.source  res_o,
  rkef_cfg_if.sink       cfg_i
);

  rkef_pkg::rkef_cfg_t   cfg_q;
  rkef_pkg::rkef_entry_t push_entry;
  rkef_pkg::rkef_entry_t head_entry;
  logic                  push, pop, full, empty;

  assign cfg_i.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kernel_size <= rkef_pkg::KernelW'(4);
      cfg_q.lower_thr   <= rkef_pkg::StrengthW'(1);
      cfg_q.upper_thr   <= rkef_pkg::StrengthMax;
      cfg_q.edge_dir    <= rkef_pkg::DIR_ANY;
      cfg_q.pick_rule   <= rkef_pkg::PICK_PEAK;
      cfg_q.z_low       <= -16'sd32767;
      cfg_q.z_high      <= 16'sd32767;
      cfg_q.zero_level  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        rkef_pkg::REG_KERNEL_SIZE: cfg_q.kernel_size <= cfg_i.data[rkef_pkg::KernelW-1:0];
        rkef_pkg::REG_LOWER_THR:   cfg_q.lower_thr   <= cfg_i.data[rkef_pkg::StrengthW-1:0];
        rkef_pkg::REG_UPPER_THR:   cfg_q.upper_thr   <= cfg_i.data[rkef_pkg::StrengthW-1:0];
        rkef_pkg::REG_EDGE_DIR:    cfg_q.edge_dir    <= cfg_i.data[rkef_pkg::DirW-1:0];
        rkef_pkg::REG_PICK_RULE:   cfg_q.pick_rule   <= cfg_i.data[rkef_pkg::PickW-1:0];
        rkef_pkg::REG_Z_LOW:       cfg_q.z_low       <= cfg_i.data[rkef_pkg::HeightW-1:0];
        rkef_pkg::REG_Z_HIGH:      cfg_q.z_high      <= cfg_i.data[rkef_pkg::HeightW-1:0];
        rkef_pkg::REG_ZERO_LEVEL:  cfg_q.zero_level  <= cfg_i.data[rkef_pkg::HeightW-1:0];
        default: ;
      endcase
    end
  end

  // window and counters
  rkef_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .samp_i  (samp_i),
    .cfg_i   (cfg_q),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // decoupling queue
  rkef_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (empty)
  );

  // evaluation and selection
  rkef_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .entry_i (head_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

>>> rtl/rkef_checker.sv
// ----------------------------------------------------------------------------
// rkef_checker
// port-level assertions for the edge finder, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rkef_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             in_row_end_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic                             out_found_i,
  input logic [rkef_pkg::OutColW-1:0]     out_column_i,
  input logic [rkef_pkg::StrengthW-1:0]   out_strength_i
);

  logic [3:0] pend_q, pend_d;
  logic       row_acc, out_acc;

  // rows accepted whose result has not yet been taken
  assign row_acc = in_valid_i && in_ready_i && in_row_end_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (row_acc && !out_acc) begin
      pend_d = pend_q + 1'b1;
    end else if (out_acc && !row_acc) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `RKEF_ASSERT_IMPLY(a_result_has_row, clk_i, rst_ni, out_valid_i, pend_q != '0, "result without a finished row")
  `RKEF_ASSERT_IMPLY(a_found_matches, clk_i, rst_ni, out_valid_i, out_found_i == (out_strength_i != '0), "found flag disagrees with strength")
  `RKEF_ASSERT_IMPLY(a_none_is_zero, clk_i, rst_ni, out_valid_i && !out_found_i, out_column_i == '0, "no edge but column not zero")
  `RKEF_ASSERT_NEXT(a_valid_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `RKEF_ASSERT_NEXT(a_payload_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_column_i) && $stable(out_strength_i) && $stable(out_found_i), "result changed while stalled")

endmodule

bind row_kernel_edge_finder rkef_checker u_rkef_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (samp_i.valid),
  .in_ready_i     (samp_i.ready),
  .in_row_end_i   (samp_i.row_end),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .out_found_i    (res_o.edge_found),
  .out_column_i   (res_o.edge_column),
  .out_strength_i (res_o.edge_strength)
);
